### rtl/tte_pkg.sv
package tte_pkg;

    localparam int TW      = 48;
    localparam int DIV_NW  = 64;
    localparam int DIV_DW  = 56;
    localparam int DIV_CW  = $clog2(DIV_NW + 1);

    localparam logic [TW-1:0] PERIOD_RESET = TW'(32768);
    localparam logic [TW-1:0] PERIOD_MIN   = TW'(6554);
    localparam logic [TW-1:0] PERIOD_MAX   = TW'(196608);
    localparam logic [TW-1:0] TAP_GAP      = TW'(262144);
    localparam logic [17:0]   NEAR_LOW     = 18'd39322;
    localparam logic [17:0]   NEAR_HIGH    = 18'd222822;
    localparam logic [31:0]   BPM_SCALE    = 32'd1006632960;
    localparam logic [17:0]   BPM_MAX      = 18'd262143;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_TDROP,
        OP_TRD_OLD,
        OP_TRD_PREV,
        OP_TPUSH,
        OP_TCLEAR,
        OP_TAVG_START,
        OP_TAVG_END,
        OP_RFAR,
        OP_RDROP,
        OP_RRD_OLD,
        OP_RPUSH,
        OP_RDIV1_START,
        OP_RDIV2_START,
        OP_RDIV2_END,
        OP_BAR_START,
        OP_BAR_END,
        OP_MEAS,
        OP_FRAC_START,
        OP_BEAT,
        OP_BPM_START,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK,
        S_TDROP, S_TDCMP, S_TCHK, S_TGAP, S_TAVG, S_TAW,
        S_RS, S_RDROP, S_RDCMP, S_RCHK, S_RFIRST, S_RD1W, S_RD2W,
        S_BAR, S_BARW, S_MEAS, S_FRAC, S_FRW, S_BPM, S_BPMW, S_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic tap;
        logic resync;
        logic t_full;
        logic t_gt1;
        logic t_beyond;
        logic t_ge4;
        logic t_gap;
        logic far;
        logic r_full;
        logic r_gt1;
        logic r_beyond;
        logic md_zero;
        logic q_zero;
        logic period_zero;
        logic div_busy;
        logic out_busy;
    } t_stat;

    // t later than base by more than span
    function automatic logic beyond(input logic [TW-1:0] t, input logic [TW-1:0] base,
                                    input logic [TW-1:0] span);
        return (t >= base) && ((t - base) > span);
    endfunction

endpackage

### rtl/tte_if.sv
interface tte_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] run_time;
    logic        tap_pulse;
    logic        resync_pulse;

    modport source(output valid, run_time, tap_pulse, resync_pulse, input ready);
    modport sink(input valid, run_time, tap_pulse, resync_pulse, output ready);
endinterface

interface tte_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] beat_time;
    logic        [17:0] tempo_bpm;

    modport source(output valid, beat_time, tempo_bpm, input ready);
    modport sink(input valid, beat_time, tempo_bpm, output ready);
endinterface

### rtl/tap_tempo_beat_clock.sv
// channel   dir  handshake           word
// i_in      in   valid/ready         run_time[47:0], tap_pulse, resync_pulse
// o_out     out  valid/ready         beat_time[47:0] signed, tempo_bpm[17:0]
// i_cfg     in   i_cfg_we, no stall  i_cfg_data[17:0] initial_beat_period
//
// One word at a time: a tick may need up to six divisions, each run in turn in the
// shared bit-serial divider.
// Each entry dropped in ring aging lengthens the work on that word.
// i_rst_n is synchronous; the rings need no clearing pass.
// A finished result waits in the output register while the next word is taken.
module tap_tempo_beat_clock
    import tte_pkg::*;
#(
    parameter int TAP_DEPTH    = 16,
    parameter int RESYNC_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_data,
    tte_in_if.sink      i_in,
    tte_out_if.source   o_out
);

    t_cmd  cmd;
    t_stat stat;

    tte_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    tte_datapath #(
        .TAP_DEPTH   (TAP_DEPTH),
        .RESYNC_DEPTH(RESYNC_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_cmd     (cmd),
        .o_stat    (stat)
    );

endmodule

### rtl/tte_div.sv
module tte_div
    import tte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_busy,
    output logic [DIV_NW-1:0] o_quot
);

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   trial;
    logic              fits;
    logic [DIV_DW:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quot[DIV_NW-1]};
        fits  = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_NW-2:0], fits};
            r_rem  <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

### rtl/tte_datapath.sv
module tte_datapath
    import tte_pkg::*;
#(
    parameter int TAP_DEPTH    = 16,
    parameter int RESYNC_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_data,
    tte_in_if.sink      i_in,
    tte_out_if.source   o_out,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);

    localparam int TIW = $clog2(TAP_DEPTH);
    localparam int TCW = $clog2(TAP_DEPTH + 1);
    localparam int RIW = $clog2(RESYNC_DEPTH);
    localparam int RCW = $clog2(RESYNC_DEPTH + 1);

    logic [TW-1:0]  r_now;
    logic           r_tap;
    logic           r_resync;
    logic [TW-1:0]  r_period;
    logic [TW-1:0]  r_mstart;
    logic [31:0]    r_mcount;
    logic [TW-1:0]  r_bar;
    logic [TW-1:0]  r_last;
    logic [TIW-1:0] r_thead;
    logic [TCW-1:0] r_tcnt;
    logic [RIW-1:0] r_rhead;
    logic [RCW-1:0] r_rcnt;
    logic [TW-1:0]  r_tap_mem [TAP_DEPTH];
    logic [TW-1:0]  r_rs_mem  [RESYNC_DEPTH];
    logic [TW-1:0]  r_tap_rd;
    logic [TW-1:0]  r_rs_rd;
    logic [TW-1:0]  r_span;
    logic           r_neg;
    logic           r_oval;
    logic [TW-1:0]  r_obeat;
    logic [17:0]    r_obpm;

    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_busy;
    logic [DIV_NW-1:0] quot;

    logic [TW-1:0]  md;
    logic [TW-1:0]  span32;
    logic [55:0]    p136;
    logic [TW-1:0]  span136;
    logic           now_ge_ms;
    logic [TW-1:0]  dms;
    logic [TW-1:0]  tdiff;
    logic [TCW-1:0] tsteps;
    logic [TW-1:0]  rspan;
    logic [DIV_DW-1:0] den2;
    logic [TW-1:0]  frac;
    logic [TW-1:0]  beat;

    function automatic logic [TIW-1:0] tap_idx(input logic [TIW-1:0] head,
                                               input logic [TCW-1:0] k);
        logic [TCW:0] s;
        s = (TCW+1)'(head) + (TCW+1)'(k);
        if (s >= (TCW+1)'(TAP_DEPTH)) begin
            s = s - (TCW+1)'(TAP_DEPTH);
        end
        return s[TIW-1:0];
    endfunction

    function automatic logic [RIW-1:0] rs_idx(input logic [RIW-1:0] head,
                                              input logic [RCW-1:0] k);
        logic [RCW:0] s;
        s = (RCW+1)'(head) + (RCW+1)'(k);
        if (s >= (RCW+1)'(RESYNC_DEPTH)) begin
            s = s - (RCW+1)'(RESYNC_DEPTH);
        end
        return s[RIW-1:0];
    endfunction

    tte_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_busy (div_busy),
        .o_quot (quot)
    );

    always_comb begin
        md        = {r_period[TW-5:0], 4'b0};
        span32    = {r_period[TW-6:0], 5'b0};
        p136      = 56'(r_period) * 56'd136;
        span136   = p136[TW-1:0];
        now_ge_ms = r_now >= r_mstart;
        dms       = now_ge_ms ? (r_now - r_mstart) : (r_mstart - r_now);
        tdiff     = (r_now >= r_tap_rd) ? (r_now - r_tap_rd) : '0;
        tsteps    = r_tcnt - 1'b1;
        rspan     = (r_now >= r_rs_rd) ? (r_now - r_rs_rd) : '0;
        den2      = {quot[DIV_DW-5:0], 4'b0};
        frac      = md == '0 ? '0 : (r_neg ? (TW'(0) - quot[TW-1:0]) : quot[TW-1:0]);
        beat      = ({r_mcount, 16'b0} + frac + r_bar) << 2;
    end

    always_comb begin
        div_start = 1'b1;
        div_num   = {dms, 16'b0};
        div_den   = DIV_DW'(md);
        case (i_cmd.op)
            OP_TAVG_START: begin
                div_num = DIV_NW'(tdiff) + DIV_NW'(tsteps >> 1);
                div_den = DIV_DW'(tsteps);
            end
            OP_RDIV1_START: begin
                div_num = DIV_NW'(rspan) + DIV_NW'(md >> 1);
            end
            OP_RDIV2_START: begin
                div_num = DIV_NW'(r_span) + DIV_NW'(den2 >> 1);
                div_den = den2;
            end
            OP_BAR_START, OP_FRAC_START: begin
            end
            OP_BPM_START: begin
                div_num = DIV_NW'(BPM_SCALE) + DIV_NW'(r_period >> 1);
                div_den = DIV_DW'(r_period);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap    <= 1'b0;
            r_resync <= 1'b0;
            r_period <= PERIOD_RESET;
            r_mstart <= '0;
            r_mcount <= '0;
            r_bar    <= '0;
            r_last   <= '0;
            r_thead  <= '0;
            r_tcnt   <= '0;
            r_rhead  <= '0;
            r_rcnt   <= '0;
            r_oval   <= 1'b0;
        end else begin
            if (i_cmd.op == OP_OUT) begin
                r_oval <= 1'b1;
            end else if (r_oval && o_out.ready) begin
                r_oval <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_tap    <= i_in.tap_pulse;
                    r_resync <= i_in.resync_pulse;
                end
                OP_CHECK: begin
                    if (r_period < PERIOD_MIN || r_period > PERIOD_MAX) begin
                        r_period <= PERIOD_RESET;
                        r_bar    <= '0;
                        r_tcnt   <= '0;
                        r_rcnt   <= '0;
                    end
                end
                OP_TDROP: begin
                    r_thead <= tap_idx(r_thead, TCW'(1));
                    r_tcnt  <= r_tcnt - 1'b1;
                end
                OP_TPUSH:    r_tcnt <= r_tcnt + 1'b1;
                OP_TCLEAR:   r_tcnt <= '0;
                OP_TAVG_END: r_period <= quot[TW-1:0];
                OP_RFAR: begin
                    r_rhead <= '0;
                    r_rcnt  <= RCW'(1);
                end
                OP_RDROP: begin
                    r_rhead <= rs_idx(r_rhead, RCW'(1));
                    r_rcnt  <= r_rcnt - 1'b1;
                end
                OP_RPUSH:     r_rcnt <= r_rcnt + 1'b1;
                OP_RDIV2_END: r_period <= quot[TW-1:0];
                OP_BAR_END: begin
                    // snap so the beat time lands on a measure boundary
                    r_bar <= md == '0 ? '0 :
                             (r_neg ? quot[TW-1:0] : (TW'(0) - quot[TW-1:0]));
                end
                OP_MEAS: begin
                    if (md != '0 && beyond(r_now, r_mstart, md)) begin
                        r_mcount <= r_mcount + 1'b1;
                        r_mstart <= r_mstart + md;
                    end
                end
                OP_BEAT: r_last <= beat;
                default: begin
                end
            endcase
            if (i_cfg_we) begin
                r_period <= TW'(i_cfg_data);
                r_tcnt   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD:     r_now <= i_in.run_time;
            OP_TRD_OLD:  r_tap_rd <= r_tap_mem[r_thead];
            OP_TRD_PREV: r_tap_rd <= r_tap_mem[tap_idx(r_thead, r_tcnt - TCW'(2))];
            OP_TPUSH:    r_tap_mem[tap_idx(r_thead, r_tcnt)] <= r_now;
            OP_RFAR:     r_rs_mem[0] <= r_now;
            OP_RRD_OLD:  r_rs_rd <= r_rs_mem[r_rhead];
            OP_RPUSH:    r_rs_mem[rs_idx(r_rhead, r_rcnt)] <= r_now;
            OP_RDIV1_START: begin
                r_span <= rspan;
            end
            OP_BAR_START, OP_FRAC_START: begin
                r_neg <= !now_ge_ms;
            end
            OP_OUT: begin
                r_obeat <= r_last;
                if (r_period == '0 || quot > DIV_NW'(BPM_MAX)) begin
                    r_obpm <= BPM_MAX;
                end else begin
                    r_obpm <= quot[17:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.in_valid    = i_in.valid;
        o_stat.tap         = r_tap;
        o_stat.resync      = r_resync;
        o_stat.t_full      = r_tcnt >= TCW'(TAP_DEPTH);
        o_stat.t_gt1       = r_tcnt > TCW'(1);
        o_stat.t_beyond    = beyond(r_now, r_tap_rd, span32);
        o_stat.t_ge4       = r_tcnt >= TCW'(4);
        o_stat.t_gap       = beyond(r_now, r_tap_rd, TAP_GAP);
        o_stat.far         = r_last[17:0] >= NEAR_LOW && r_last[17:0] <= NEAR_HIGH;
        o_stat.r_full      = r_rcnt >= RCW'(RESYNC_DEPTH);
        o_stat.r_gt1       = r_rcnt > RCW'(1);
        o_stat.r_beyond    = beyond(r_now, r_rs_rd, span136);
        o_stat.md_zero     = md == '0;
        o_stat.q_zero      = quot == '0;
        o_stat.period_zero = r_period == '0;
        o_stat.div_busy    = div_busy;
        o_stat.out_busy    = r_oval && !o_out.ready;
    end

    assign i_in.ready      = i_cmd.in_ready;
    assign o_out.valid     = r_oval;
    assign o_out.beat_time = r_obeat;
    assign o_out.tempo_bpm = r_obpm;

endmodule

### rtl/tte_ctrl.sv
module tte_ctrl
    import tte_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state  = i_stat.tap ? S_TDROP : S_RS;
            end
            // age the tap ring before the append
            S_TDROP: begin
                if (i_stat.t_full) begin
                    o_cmd.op = OP_TDROP;
                end else if (i_stat.t_gt1) begin
                    o_cmd.op = OP_TRD_OLD;
                    n_state  = S_TDCMP;
                end else begin
                    o_cmd.op = OP_TPUSH;
                    n_state  = S_TCHK;
                end
            end
            S_TDCMP: begin
                if (i_stat.t_beyond) begin
                    o_cmd.op = OP_TDROP;
                    n_state  = S_TDROP;
                end else begin
                    o_cmd.op = OP_TPUSH;
                    n_state  = S_TCHK;
                end
            end
            S_TCHK: begin
                if (i_stat.t_ge4) begin
                    o_cmd.op = OP_TRD_PREV;
                    n_state  = S_TGAP;
                end else begin
                    n_state = S_RS;
                end
            end
            S_TGAP: begin
                if (i_stat.t_gap) begin
                    o_cmd.op = OP_TCLEAR;
                    n_state  = S_RS;
                end else begin
                    o_cmd.op = OP_TRD_OLD;
                    n_state  = S_TAVG;
                end
            end
            S_TAVG: begin
                o_cmd.op = OP_TAVG_START;
                n_state  = S_TAW;
            end
            S_TAW: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_TAVG_END;
                    n_state  = S_RS;
                end
            end
            S_RS: begin
                if (!i_stat.resync) begin
                    n_state = S_MEAS;
                end else if (i_stat.far) begin
                    o_cmd.op = OP_RFAR;
                    n_state  = S_BAR;
                end else begin
                    n_state = S_RDROP;
                end
            end
            S_RDROP: begin
                if (i_stat.r_full) begin
                    o_cmd.op = OP_RDROP;
                end else if (i_stat.r_gt1) begin
                    o_cmd.op = OP_RRD_OLD;
                    n_state  = S_RDCMP;
                end else begin
                    o_cmd.op = OP_RPUSH;
                    n_state  = S_RCHK;
                end
            end
            S_RDCMP: begin
                if (i_stat.r_beyond) begin
                    o_cmd.op = OP_RDROP;
                    n_state  = S_RDROP;
                end else begin
                    o_cmd.op = OP_RPUSH;
                    n_state  = S_RCHK;
                end
            end
            S_RCHK: begin
                if (i_stat.r_gt1 && !i_stat.md_zero) begin
                    o_cmd.op = OP_RRD_OLD;
                    n_state  = S_RFIRST;
                end else begin
                    n_state = S_BAR;
                end
            end
            S_RFIRST: begin
                o_cmd.op = OP_RDIV1_START;
                n_state  = S_RD1W;
            end
            S_RD1W: begin
                if (!i_stat.div_busy) begin
                    if (i_stat.q_zero) begin
                        n_state = S_BAR;
                    end else begin
                        o_cmd.op = OP_RDIV2_START;
                        n_state  = S_RD2W;
                    end
                end
            end
            S_RD2W: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_RDIV2_END;
                    n_state  = S_BAR;
                end
            end
            S_BAR: begin
                if (i_stat.md_zero) begin
                    o_cmd.op = OP_BAR_END;
                    n_state  = S_MEAS;
                end else begin
                    o_cmd.op = OP_BAR_START;
                    n_state  = S_BARW;
                end
            end
            S_BARW: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_BAR_END;
                    n_state  = S_MEAS;
                end
            end
            S_MEAS: begin
                o_cmd.op = OP_MEAS;
                n_state  = S_FRAC;
            end
            S_FRAC: begin
                if (i_stat.md_zero) begin
                    o_cmd.op = OP_BEAT;
                    n_state  = S_BPM;
                end else begin
                    o_cmd.op = OP_FRAC_START;
                    n_state  = S_FRW;
                end
            end
            S_FRW: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_BEAT;
                    n_state  = S_BPM;
                end
            end
            S_BPM: begin
                if (i_stat.period_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_BPM_START;
                    n_state  = S_BPMW;
                end
            end
            S_BPMW: begin
                if (!i_stat.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/tte_checker.sv
module tte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_beat_time,
    input logic [17:0] i_tempo_bpm
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_beat_time) && $stable(i_tempo_bpm))
        else $error("stalled result word changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a word is in work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tap_tempo_beat_clock tte_checker u_tte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_beat_time(o_out.beat_time),
    .i_tempo_bpm(o_out.tempo_bpm)
);

### tb/sv/beat_clock_checker.sv
`timescale 1ns / 100ps

module beat_clock_checker
    import tte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_data,
    tte_in_if           i_in,
    tte_out_if          i_out,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [63:0] TIME_MASK = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [47:0] beat_time;
        logic [17:0] tempo_bpm;
    } t_beat_word;

    t_beat_word  beat_q[$];

    logic [63:0] period;
    logic [63:0] mstart;
    logic [31:0] mcount;
    logic [63:0] bar_ofs;
    logic [63:0] last_beat;
    logic [63:0] tap_ring[16];
    int          tap_cnt;
    logic [63:0] sync_ring[16];
    int          sync_cnt;

    function automatic logic later_by(input logic [63:0] t, input logic [63:0] base,
                                      input logic [63:0] span);
        return (t >= base) && ((t - base) > span);
    endfunction

    // signed Q.16 measure fraction from b to a, wrapped in 64 bits
    function automatic logic [63:0] frac_of(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] md);
        logic [63:0] d;
        if (md == 0) return 64'd0;
        if (a >= b) begin
            d = a - b;
            return (d << 16) / md;
        end
        d = b - a;
        return 64'd0 - ((d << 16) / md);
    endfunction

    // age out old entries, then append
    function automatic void age_push(inout logic [63:0] ring[16], inout int cnt,
                                     input int depth, input logic [63:0] span,
                                     input logic [63:0] t);
        while (cnt > 0 && (cnt >= depth || (cnt > 1 && later_by(t, ring[0], span)))) begin
            for (int i = 0; i < 15; i++) ring[i] = ring[i+1];
            cnt--;
        end
        if (cnt < depth) begin
            ring[cnt] = t;
            cnt++;
        end
    endfunction

    function automatic t_beat_word advance_tick(input logic [47:0] run_time,
                                                input logic tap, input logic resync);
        logic [63:0] now, md, prev, first, newest, diff, steps, span, meas, den;
        logic [63:0] beat, bpm;
        logic [17:0] r;
        t_beat_word  w;
        now = {16'd0, run_time};
        if (period < 64'(PERIOD_MIN) || period > 64'(PERIOD_MAX)) begin
            period   = 64'(PERIOD_RESET);
            bar_ofs  = 0;
            tap_cnt  = 0;
            sync_cnt = 0;
        end
        if (tap) begin
            age_push(tap_ring, tap_cnt, 16, (period * 32) & TIME_MASK, now);
            if (tap_cnt >= 4) begin
                prev = tap_ring[tap_cnt-2];
                if (later_by(now, prev, 64'(TAP_GAP))) begin
                    tap_cnt = 0;
                end else begin
                    first  = tap_ring[0];
                    newest = tap_ring[tap_cnt-1];
                    diff   = (newest >= first) ? newest - first : 64'd0;
                    steps  = 64'(tap_cnt - 1);
                    period = ((diff + steps / 2) / steps) & TIME_MASK;
                end
            end
        end
        if (resync) begin
            r  = last_beat[17:0];
            md = (period * 16) & TIME_MASK;
            if (r >= NEAR_LOW && r <= NEAR_HIGH) begin
                // far from a bar line: restart the store
                sync_ring[0] = now;
                sync_cnt     = 1;
            end else begin
                age_push(sync_ring, sync_cnt, 8, (period * 136) & TIME_MASK, now);
                if (sync_cnt > 1 && md != 0) begin
                    first = sync_ring[0];
                    span  = (now >= first) ? now - first : 64'd0;
                    meas  = (span + md / 2) / md;
                    if (meas > 0) begin
                        den    = meas * 16;
                        period = ((span + den / 2) / den) & TIME_MASK;
                    end
                end
            end
            md      = (period * 16) & TIME_MASK;
            bar_ofs = (64'd0 - frac_of(now, mstart, md)) & TIME_MASK;
        end
        md = (period * 16) & TIME_MASK;
        if (md > 0 && later_by(now, mstart, md)) begin
            mcount++;
            mstart = (mstart + md) & TIME_MASK;
        end
        beat      = ({32'd0, mcount} << 16) + frac_of(now, mstart, md) + bar_ofs;
        beat      = (beat * 4) & TIME_MASK;
        last_beat = beat;
        if (period == 0) begin
            bpm = 64'(BPM_MAX);
        end else begin
            bpm = (64'(BPM_SCALE) + period / 2) / period;
            if (bpm > 64'(BPM_MAX)) bpm = 64'(BPM_MAX);
        end
        w.beat_time = beat[47:0];
        w.tempo_bpm = bpm[17:0];
        return w;
    endfunction

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_beat_word got, want;
        if (!i_rst_n) begin
            period    = 64'(PERIOD_RESET);
            mstart    = 0;
            mcount    = 0;
            bar_ofs   = 0;
            last_beat = 0;
            tap_cnt   = 0;
            sync_cnt  = 0;
            beat_q.delete();
        end else begin
            if (i_cfg_we) begin
                period  = {46'd0, i_cfg_data};
                tap_cnt = 0;
            end
            if (i_in.valid && i_in.ready)
                beat_q.insert(beat_q.size(), advance_tick(i_in.run_time, i_in.tap_pulse,
                                                          i_in.resync_pulse));
            if (i_out.valid && i_out.ready) begin
                got.beat_time = i_out.beat_time;
                got.tempo_bpm = i_out.tempo_bpm;
                if (beat_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected word: beat_time %h tempo_bpm %0d",
                                 got.beat_time, got.tempo_bpm);
                end else begin
                    want = beat_q.pop_front();
                    if (got.beat_time !== want.beat_time
                        || got.tempo_bpm !== want.tempo_bpm) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: beat_time %h exp %h, tempo_bpm %0d exp %0d",
                                     got.beat_time, want.beat_time,
                                     got.tempo_bpm, want.tempo_bpm);
                    end
                end
            end
        end
        o_pending = beat_q.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 500;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [17:0] i_cfg_data;
    int          errors;
    int          pending;
    int          sent;
    int          quiet;
    logic        calm;
    logic        hold_req;
    logic [47:0] now_t;

    tte_in_if  in_ch();
    tte_out_if out_ch();

    tap_tempo_beat_clock dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source)
    );

    beat_clock_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // stall watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // result side back-pressure
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
        end
    end

    task automatic send_tick(input logic [47:0] t, input logic tap, input logic rs);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.run_time     <= t;
        in_ch.tap_pulse    <= tap;
        in_ch.resync_pulse <= rs;
        do @(posedge i_clk); while (!in_ch.ready);
        now_t = t;
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [17:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic directed();
        send_tick(48'd0, 1'b0, 1'b0);
        send_tick(48'd0, 1'b1, 1'b1);
        send_tick(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
        send_tick(48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
        // time runs backward
        send_tick(48'd100, 1'b0, 1'b0);
        for (int i = 1; i <= 6; i++) send_tick(48'd100 + 48'(i * 32768), 1'b1, 1'b0);
        // tap after a long gap
        send_tick(now_t + 48'd300000, 1'b1, 1'b0);
        for (int i = 0; i < 4; i++) send_tick(now_t + 48'd524288, 1'b0, 1'b1);
        send_tick(now_t + 48'd200000, 1'b0, 1'b1);
        send_tick(now_t + 48'd1000, 1'b1, 1'b1);
        // equal taps drive the period to zero
        for (int i = 0; i < 4; i++) send_tick(now_t, 1'b1, 1'b0);
        send_tick(now_t + 48'd500, 1'b0, 1'b0);
    endtask

    task automatic random_ticks(input int count);
        int          stop, n, kind;
        logic [47:0] iv, t;
        stop = sent + count;
        while (sent < stop) begin
            kind = $urandom_range(0, 9);
            iv   = 48'($urandom_range(6554, 196608));
            if (kind <= 3) begin
                n = $urandom_range(4, 20);
                for (int i = 0; i < n; i++)
                    send_tick(now_t + iv + 48'($urandom_range(0, iv / 8)) - iv / 16,
                              1'b1, $urandom_range(0, 9) == 0);
            end else if (kind <= 5) begin
                n = $urandom_range(2, 9);
                for (int i = 0; i < n; i++)
                    send_tick(now_t + iv * 16 * 48'($urandom_range(1, 2))
                              + 48'($urandom_range(0, 4000)) - 48'd2000,
                              $urandom_range(0, 7) == 0, 1'b1);
            end else if (kind <= 7) begin
                n = $urandom_range(3, 15);
                for (int i = 0; i < n; i++)
                    send_tick(now_t + 48'($urandom_range(0, 4369)),
                              $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0);
            end else if (kind == 8) begin
                t = {$urandom, $urandom};
                send_tick($urandom_range(0, 1) ? t : now_t + (t >> $urandom_range(0, 47)),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                send_tick(now_t - 48'($urandom_range(0, 1 << 20)),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = 18'd0;
        in_ch.valid        = 1'b0;
        in_ch.run_time     = 48'd0;
        in_ch.tap_pulse    = 1'b0;
        in_ch.resync_pulse = 1'b0;
        out_ch.ready       = 1'b0;
        calm               = 1'b0;
        hold_req           = 1'b0;
        quiet              = 0;
        sent               = 0;
        now_t              = 48'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();
        write_period(18'd6554);
        random_ticks(100);
        write_period(18'd196608);
        hold_req = 1'b1;
        random_ticks(50);
        // let the block run dry before going on
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        random_ticks(50);
        write_period(18'($urandom_range(6554, 196608)));
        random_ticks(100);
        write_period(18'd32768);
        calm = 1'b1;
        random_ticks(100);
        drain();

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
